// ===== design/state_space_euler_filter_defines.svh =====
// Assertion macros used by the state-space Euler filter top level.
`ifndef STATE_SPACE_EULER_FILTER_DEFINES_SVH
`define STATE_SPACE_EULER_FILTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sse: same-cycle check failed");

// Antecedent implies consequent in the cycle after.
`define SSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sse: next-cycle check failed");

`endif

// ===== design/sse_pkg.sv =====
// Package: constants, codes and control types of the state-space Euler filter.
package sse_pkg;

  // Number of integrator states the block holds
  localparam int MAX_STATES = 4;
  localparam int IDX_W      = 2;

  localparam int W_SAMPLE = 32;
  localparam int W_STATE  = 48;
  localparam int W_ACC    = 64;
  localparam int W_MOP    = 33;
  localparam int W_PROD   = 66;
  localparam int W_CFG    = 64;
  localparam int W_REGIDX = 3;

  // Register indexes on the configuration port
  localparam logic [W_REGIDX-1:0] REG_ORDER   = 3'd0;
  localparam logic [W_REGIDX-1:0] REG_STEP    = 3'd1;
  localparam logic [W_REGIDX-1:0] REG_FB_LOW  = 3'd2;
  localparam logic [W_REGIDX-1:0] REG_FB_HIGH = 3'd3;
  localparam logic [W_REGIDX-1:0] REG_OW_LOW  = 3'd4;
  localparam logic [W_REGIDX-1:0] REG_OW_HIGH = 3'd5;
  localparam logic [W_REGIDX-1:0] REG_DIRECT  = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_CLIPF,
    ST_TOPUP,
    ST_DIRECT,
    ST_BETA,
    ST_HSTEP,
    ST_FINAL
  } seq_state_t;

  // Shared multiplier phases
  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LOW,
    MP_SUM
  } mul_phase_t;

  // Operand pair fed to the multiplier
  typedef enum logic [2:0] {
    OP_ALPHA,
    OP_TOP,
    OP_DIRECT,
    OP_BETA,
    OP_HSTEP
  } op_sel_t;

  // Where a finished product goes
  typedef enum logic [2:0] {
    AP_NONE,
    AP_ACC_SUB,
    AP_ACC_LOAD,
    AP_ACC_ADD,
    AP_STATE
  } apply_t;

  typedef struct packed {
    logic             start;
    op_sel_t          op;
    apply_t           apply;
    logic [IDX_W-1:0] idx;
    logic             clip_f;
    logic             final_load;
    logic             ready;
  } seq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

// ===== design/sse_mul.sv =====
// Shared multiplier: weight or step times a 48-bit value, floored to Q.16.
module sse_mul
  import sse_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       step_mode,
  input  logic signed [W_MOP-1:0]    a,
  input  logic signed [W_STATE-1:0]  b,
  output logic signed [W_ACC-1:0]    term,
  output mul_status_t                status
);

  mul_phase_t phase, phase_next;
  logic                     done;
  logic signed [W_MOP-1:0]  a_q;
  logic [15:0]              blo_q;
  logic                     hs_q;
  logic signed [W_MOP-1:0]  mul_a, mul_b;
  logic signed [W_PROD-1:0] mul_q, part_q, term_pre, term_hs;

  // Phase sequence
  always_comb begin
    phase_next = phase;
    case (phase)
      MP_IDLE: if (start) phase_next = MP_LOW;
      MP_LOW:  phase_next = MP_SUM;
      MP_SUM:  phase_next = MP_IDLE;
      default: phase_next = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == MP_SUM);
    end
  end

  // One multiplier: high part of b first, then the unsigned low 16 bits
  always_comb begin
    if (phase == MP_LOW) begin
      mul_a = a_q;
      mul_b = $signed({17'b0, blo_q});
    end else begin
      mul_a = a;
      mul_b = $signed({b[W_STATE-1], b[W_STATE-1:16]});
    end
  end

  // floor(a*b/2^16) = hi + (lo >>> 16); step products take another >>> 16
  assign term_pre = part_q + (mul_q >>> 16);
  assign term_hs  = term_pre >>> 16;

  always_ff @(posedge clk) begin
    if (phase == MP_IDLE && start) begin
      mul_q <= mul_a * mul_b;
      a_q   <= a;
      blo_q <= b[15:0];
      hs_q  <= step_mode;
    end else if (phase == MP_LOW) begin
      part_q <= mul_q;
      mul_q  <= mul_a * mul_b;
    end else if (phase == MP_SUM) begin
      term <= hs_q ? term_hs[W_ACC-1:0] : term_pre[W_ACC-1:0];
    end
  end

  always_comb begin
    status.busy = (phase != MP_IDLE);
    status.done = done;
  end

endmodule

// ===== design/sse_ctrl.sv =====
// Sequencer: walks the feedback, integration and output products of one sample; a clear goes straight to the last step.
module sse_ctrl
  import sse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             action,
  input  logic [IDX_W-1:0] top_idx,
  input  mul_status_t      mul_stat,
  input  logic             out_free,
  output seq_ctrl_t        ctrl
);

  seq_state_t       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             issued, issued_next;
  logic             product;
  logic             fin;

  assign product = (state == ST_ALPHA) || (state == ST_TOPUP) || (state == ST_DIRECT) ||
                   (state == ST_BETA) || (state == ST_HSTEP);
  assign fin     = issued && mul_stat.done;

  // Next state
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    issued_next = issued;
    if (product) begin
      if (!issued) issued_next = 1'b1;
      else if (mul_stat.done) issued_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = action ? ST_FINAL : ST_ALPHA;
          idx_next   = '0;
        end
      end
      ST_ALPHA: begin
        if (fin) begin
          if (idx == top_idx) state_next = ST_CLIPF;
          else idx_next = idx + 1'b1;
        end
      end
      ST_CLIPF: begin
        state_next = ST_TOPUP;
        idx_next   = top_idx;
      end
      ST_TOPUP:  if (fin) state_next = ST_DIRECT;
      ST_DIRECT: if (fin) state_next = ST_BETA;
      ST_BETA: begin
        if (fin) begin
          if (idx == '0) state_next = ST_FINAL;
          else begin
            state_next = ST_HSTEP;
            idx_next   = idx - 1'b1;
          end
        end
      end
      ST_HSTEP:  if (fin) state_next = ST_BETA;
      ST_FINAL:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      issued <= issued_next;
    end
  end

  // Outputs
  always_comb begin
    ctrl.start      = product && !issued;
    ctrl.idx        = idx;
    ctrl.clip_f     = (state == ST_CLIPF);
    ctrl.final_load = (state == ST_FINAL) && out_free;
    ctrl.ready      = (state == ST_IDLE);
    ctrl.op         = OP_ALPHA;
    ctrl.apply      = AP_NONE;
    case (state)
      ST_ALPHA: begin
        ctrl.op = OP_ALPHA;
        if (fin) ctrl.apply = AP_ACC_SUB;
      end
      ST_TOPUP: begin
        ctrl.op = OP_TOP;
        if (fin) ctrl.apply = AP_STATE;
      end
      ST_DIRECT: begin
        ctrl.op = OP_DIRECT;
        if (fin) ctrl.apply = AP_ACC_LOAD;
      end
      ST_BETA: begin
        ctrl.op = OP_BETA;
        if (fin) ctrl.apply = AP_ACC_ADD;
      end
      ST_HSTEP: begin
        ctrl.op = OP_HSTEP;
        if (fin) ctrl.apply = AP_STATE;
      end
      default: begin
        ctrl.op    = OP_ALPHA;
        ctrl.apply = AP_NONE;
      end
    endcase
  end

endmodule

// ===== design/state_space_euler_filter.sv =====
// Top level: state-space filter stepped by semi-implicit Euler, on one shared multiplier.
//
//  beat        signals                                  direction
//  sample      sample_valid/sample_stall, action, sample_in   in
//  result      result_valid/result_stall, filtered_out, saturated out
//  config      cfg_write, cfg_index, cfg_data           in, no handshake
//
// Each product runs through issue, low half, sum and apply on the shared 33x33
// multiplier; a sample of order n needs 3n+1 products before the result register is
// loaded. A clear goes from acceptance straight to the final step, which loads the
// result register once the output side is free.
// Synchronous reset sets the registers to their defaults and zeroes the states.
// A new sample is taken while a result still waits; a stalled result only holds the
// sequencer in its last step.
`include "state_space_euler_filter_defines.svh"
module state_space_euler_filter
  import sse_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic                       action,
  input  logic signed [W_SAMPLE-1:0] sample_in,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [W_SAMPLE-1:0] filtered_out,
  output logic                       saturated,
  input  logic                       cfg_write,
  input  logic [W_REGIDX-1:0]        cfg_index,
  input  logic [W_CFG-1:0]           cfg_data
);

  // Configuration registers
  logic [2:0]  order_in_use;
  logic [31:0] step_size;
  logic [63:0] feedback_weights_low, feedback_weights_high;
  logic [63:0] output_weights_low, output_weights_high;
  logic [31:0] direct_weight;

  logic signed [W_STATE-1:0]  x [MAX_STATES];
  logic signed [W_ACC-1:0]    acc;
  logic signed [W_SAMPLE-1:0] sample_q;
  logic                       flag;

  seq_ctrl_t   ctrl;
  mul_status_t mul_stat;
  logic        accept, out_free;
  logic [2:0]  n_eff;
  logic [IDX_W-1:0] top_idx, idx_up;

  logic [63:0] fb_pair, ow_pair;
  logic [31:0] alpha_w, beta_w;
  logic signed [W_MOP-1:0]   op_a;
  logic signed [W_STATE-1:0] op_b;
  logic                      step_mode;
  logic signed [W_ACC-1:0]   term;

  logic signed [W_ACC:0]     acc_sum;
  logic                      acc_ovf;
  logic signed [W_ACC-1:0]   acc_sat;
  logic signed [W_STATE:0]   st_sum;
  logic                      st_ovf;
  logic signed [W_STATE-1:0] st_new;
  logic                      f_ok, y_ok;
  logic signed [W_ACC-1:0]   f_val;
  logic signed [W_SAMPLE-1:0] y_val;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = !ctrl.ready;
  assign out_free     = !result_valid || !result_stall;

  // Effective order: zero acts as one, above the state count clamps
  always_comb begin
    if (order_in_use == 3'd0) n_eff = 3'd1;
    else if (order_in_use > 3'(MAX_STATES)) n_eff = 3'(MAX_STATES);
    else n_eff = order_in_use;
  end
  assign top_idx = IDX_W'(n_eff - 3'd1);
  assign idx_up  = ctrl.idx + 1'b1;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (action),
    .top_idx  (top_idx),
    .mul_stat (mul_stat),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Weight selection by state index
  assign fb_pair = ctrl.idx[1] ? feedback_weights_high : feedback_weights_low;
  assign ow_pair = ctrl.idx[1] ? output_weights_high : output_weights_low;
  assign alpha_w = ctrl.idx[0] ? fb_pair[63:32] : fb_pair[31:0];
  assign beta_w  = ctrl.idx[0] ? ow_pair[63:32] : ow_pair[31:0];

  // Operand pair for the multiplier
  always_comb begin
    step_mode = 1'b0;
    case (ctrl.op)
      OP_ALPHA: begin
        op_a = $signed({alpha_w[31], alpha_w});
        op_b = x[ctrl.idx];
      end
      OP_TOP: begin
        op_a      = $signed({1'b0, step_size});
        op_b      = acc[W_STATE-1:0];
        step_mode = 1'b1;
      end
      OP_DIRECT: begin
        op_a = $signed({direct_weight[31], direct_weight});
        op_b = {{(W_STATE-W_SAMPLE){sample_q[W_SAMPLE-1]}}, sample_q};
      end
      OP_BETA: begin
        op_a = $signed({beta_w[31], beta_w});
        op_b = x[ctrl.idx];
      end
      OP_HSTEP: begin
        op_a      = $signed({1'b0, step_size});
        op_b      = x[idx_up];
        step_mode = 1'b1;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  sse_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (ctrl.start),
    .step_mode (step_mode),
    .a         (op_a),
    .b         (op_b),
    .term      (term),
    .status    (mul_stat)
  );

  // Saturating 64-bit accumulate
  always_comb begin
    if (ctrl.apply == AP_ACC_SUB) acc_sum = {acc[W_ACC-1], acc} - {term[W_ACC-1], term};
    else acc_sum = {acc[W_ACC-1], acc} + {term[W_ACC-1], term};
    acc_ovf = acc_sum[W_ACC] ^ acc_sum[W_ACC-1];
    acc_sat = acc_sum[W_ACC] ? {1'b1, {(W_ACC-1){1'b0}}} : {1'b0, {(W_ACC-1){1'b1}}};
  end

  // State update, clipped to 48 bits
  always_comb begin
    st_sum = {x[ctrl.idx][W_STATE-1], x[ctrl.idx]} + term[W_STATE:0];
    st_ovf = st_sum[W_STATE] ^ st_sum[W_STATE-1];
    st_new = st_ovf ? (st_sum[W_STATE] ? {1'b1, {(W_STATE-1){1'b0}}}
                                       : {1'b0, {(W_STATE-1){1'b1}}})
                    : st_sum[W_STATE-1:0];
  end

  // Derivative clip to 48 bits and output clip to 32 bits
  always_comb begin
    f_ok  = (&acc[W_ACC-1:W_STATE-1]) || !(|acc[W_ACC-1:W_STATE-1]);
    f_val = f_ok ? acc
                 : (acc[W_ACC-1] ? {{(W_ACC-W_STATE+1){1'b1}}, {(W_STATE-1){1'b0}}}
                                 : {{(W_ACC-W_STATE+1){1'b0}}, {(W_STATE-1){1'b1}}});
    y_ok  = (&acc[W_ACC-1:W_SAMPLE-1]) || !(|acc[W_ACC-1:W_SAMPLE-1]);
    y_val = y_ok ? acc[W_SAMPLE-1:0]
                 : (acc[W_ACC-1] ? {1'b1, {(W_SAMPLE-1){1'b0}}}
                                 : {1'b0, {(W_SAMPLE-1){1'b1}}});
  end

  // Configuration, states and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      order_in_use          <= 3'd2;
      step_size             <= 32'd4294967;
      feedback_weights_low  <= '0;
      feedback_weights_high <= '0;
      output_weights_low    <= '0;
      output_weights_high   <= '0;
      direct_weight         <= '0;
      for (int i = 0; i < MAX_STATES; i++) x[i] <= '0;
      result_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ORDER:   order_in_use          <= cfg_data[2:0];
          REG_STEP:    step_size             <= cfg_data[31:0];
          REG_FB_LOW:  feedback_weights_low  <= cfg_data;
          REG_FB_HIGH: feedback_weights_high <= cfg_data;
          REG_OW_LOW:  output_weights_low    <= cfg_data;
          REG_OW_HIGH: output_weights_high   <= cfg_data;
          REG_DIRECT:  direct_weight         <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (accept && action) begin
        for (int i = 0; i < MAX_STATES; i++) x[i] <= '0;
      end else if (ctrl.apply == AP_STATE) begin
        x[ctrl.idx] <= st_new;
      end
      if (ctrl.final_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // Accumulator, flag and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_in;
      acc      <= action ? '0 : {{(W_ACC-W_SAMPLE){sample_in[W_SAMPLE-1]}}, sample_in};
      flag     <= 1'b0;
    end else begin
      case (ctrl.apply)
        AP_ACC_SUB, AP_ACC_ADD: begin
          acc <= acc_ovf ? acc_sat : acc_sum[W_ACC-1:0];
          if (acc_ovf) flag <= 1'b1;
        end
        AP_ACC_LOAD: acc <= term;
        AP_STATE:    if (st_ovf) flag <= 1'b1;
        default: ;
      endcase
      if (ctrl.clip_f) begin
        acc <= f_val;
        if (!f_ok) flag <= 1'b1;
      end
    end
    if (ctrl.final_load) begin
      filtered_out <= y_val;
      saturated    <= flag || !y_ok;
    end
  end

  `SSE_ASSERT_IMP(a_issue_unit_free, ctrl.start, !mul_stat.busy && !mul_stat.done)
  `SSE_ASSERT_IMP(a_product_used, mul_stat.done, ctrl.apply != AP_NONE)
  `SSE_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall)

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the state-space Euler filter: queued stimulus, bit-exact predictor.
`timescale 1ns / 100ps

module tb;
  import sse_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int MAX_PRINTS     = 60;

  // Index 7 is not a register; writes there must be ignored
  localparam logic [W_REGIDX-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [63:0] S64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_LO = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_LO = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] S32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_LO = 64'shFFFF_FFFF_8000_0000;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic        clear;
    logic [31:0] smp;
  } sample_item_t;

  typedef struct packed {
    logic [31:0] y;
    logic        sat;
  } filt_result_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic                       action = 1'b0;
  logic signed [W_SAMPLE-1:0] sample_in = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [W_SAMPLE-1:0] filtered_out;
  logic                       saturated;
  logic                       cfg_write = 1'b0;
  logic [W_REGIDX-1:0]        cfg_index = '0;
  logic [W_CFG-1:0]           cfg_data = '0;

  state_space_euler_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .action       (action),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered_out (filtered_out),
    .saturated    (saturated),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor copy of registers and integrator states, at reset values
  logic [2:0]         cfg_order  = 3'd2;
  logic [31:0]        cfg_step   = 32'd4294967;
  logic [63:0]        cfg_fb_lo  = '0;
  logic [63:0]        cfg_fb_hi  = '0;
  logic [63:0]        cfg_ow_lo  = '0;
  logic [63:0]        cfg_ow_hi  = '0;
  logic [31:0]        cfg_direct = '0;
  logic signed [47:0] x_state [MAX_STATES] = '{default: '0};
  logic               clip_seen;

  sample_item_t queued_samples [$];
  filt_result_t expected_outputs [$];
  sample_item_t cur_item;
  int           error_count = 0;
  logic         hold_go = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // floor(w * s / 2^16), exact product
  function automatic logic signed [63:0] wmul(input logic signed [31:0] w,
                                              input logic signed [47:0] s);
    logic signed [79:0] p;
    p = w * s;
    return 64'(p >>> 16);
  endfunction

  // floor(h * v / 2^32), h unsigned Q0.32
  function automatic logic signed [63:0] hmul(input logic [31:0] h,
                                              input logic signed [47:0] v);
    logic signed [32:0] hs;
    logic signed [80:0] p;
    hs = {1'b0, h};
    p  = hs * v;
    return 64'(p >>> 32);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      clip_seen = 1'b1;
      return s[64] ? S64_LO : S64_HI;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    if (v > hi) begin
      clip_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic logic signed [31:0] weight_at(input logic [63:0] lo,
                                                   input logic [63:0] hi, input int i);
    logic [63:0] w;
    w = (i < 2) ? lo : hi;
    return (i % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  // One Euler step; updates the predictor states
  function automatic filt_result_t euler_step(input sample_item_t it);
    filt_result_t       r;
    int                 n;
    int                 top;
    logic signed [63:0] acc;
    logic signed [63:0] f;
    logic signed [63:0] y;
    logic signed [31:0] smp;
    if (it.clear) begin
      for (int i = 0; i < MAX_STATES; i++) x_state[i] = '0;
      r.y   = '0;
      r.sat = 1'b0;
      return r;
    end
    n = int'(cfg_order);
    if (n < 1) n = 1;
    if (n > MAX_STATES) n = MAX_STATES;
    top       = n - 1;
    clip_seen = 1'b0;
    smp       = $signed(it.smp);

    // top derivative from the old states
    acc = 64'(smp);
    for (int i = 0; i < n; i++)
      acc = add_sat(acc, -wmul(weight_at(cfg_fb_lo, cfg_fb_hi, i), x_state[i]));
    f = clamp(acc, S48_LO, S48_HI);

    x_state[top] = 48'(clamp(x_state[top] + hmul(cfg_step, f[47:0]), S48_LO, S48_HI));
    y = wmul($signed(cfg_direct), 48'(smp));
    y = add_sat(y, wmul(weight_at(cfg_ow_lo, cfg_ow_hi, top), x_state[top]));

    // lower states integrate the freshly updated state above
    for (int k = top - 1; k >= 0; k--) begin
      x_state[k] = 48'(clamp(x_state[k] + hmul(cfg_step, x_state[k + 1]), S48_LO, S48_HI));
      y = add_sat(y, wmul(weight_at(cfg_ow_lo, cfg_ow_hi, k), x_state[k]));
    end

    y     = clamp(y, S32_LO, S32_HI);
    r.y   = y[31:0];
    r.sat = clip_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers

  task automatic report(input string what);
    if (error_count < MAX_PRINTS)
      $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if (r < 8) return $urandom;
    if (r == 8) return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    return '0;
  endfunction

  function automatic logic [31:0] rand_step();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(32'h0010_0000, 32'h1000_0000);
    if (r < 8) return $urandom;
    if (r == 8) return '0;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic sample_item_t rand_item();
    sample_item_t it;
    int           r;
    it.clear = ($urandom_range(0, 99) < 4);
    r        = $urandom_range(0, 99);
    if (r < 60)      it.smp = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    else if (r < 85) it.smp = $urandom;
    else if (r < 92) it.smp = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    else             it.smp = $urandom_range(0, 512) - 256;
    return it;
  endfunction

  task automatic push_item(input logic clr, input logic [31:0] smp);
    sample_item_t it;
    it.clear = clr;
    it.smp   = smp;
    queued_samples.push_back(it);
  endtask

  task automatic write_reg(input logic [W_REGIDX-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ORDER:   cfg_order  = data[2:0];
      REG_STEP:    cfg_step   = data[31:0];
      REG_FB_LOW:  cfg_fb_lo  = data;
      REG_FB_HIGH: cfg_fb_hi  = data;
      REG_OW_LOW:  cfg_ow_lo  = data;
      REG_OW_HIGH: cfg_ow_hi  = data;
      REG_DIRECT:  cfg_direct = data[31:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers carry junk
  task automatic set_config(input logic [2:0] ord, input logic [31:0] h,
                            input logic [63:0] fl, input logic [63:0] fh,
                            input logic [63:0] ol, input logic [63:0] oh,
                            input logic [31:0] d);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_ORDER, {junk[63:3], ord});
    write_reg(REG_STEP, {junk[31:0], h});
    write_reg(REG_FB_LOW, fl);
    write_reg(REG_FB_HIGH, fh);
    write_reg(REG_OW_LOW, ol);
    write_reg(REG_OW_HIGH, oh);
    write_reg(REG_DIRECT, {junk[47:16], d});
    @(negedge clk);
  endtask

  // Wait until every queued sample is through and every result is back
  task automatic drain();
    while (queued_samples.size() != 0 || sample_valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- sample driver

  always @(posedge clk) begin : sample_driver
    logic fire;
    int   send_gap;
    int   send_calm;
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      fire = sample_valid && !sample_stall;
      if (fire)
        expected_outputs.push_back(euler_step(cur_item));
      if (sample_valid && !fire) begin
        // stalled beat holds its payload
      end else if (send_gap > 0) begin
        send_gap--;
        sample_valid <= 1'b0;
      end else if (queued_samples.size() != 0) begin
        cur_item = queued_samples.pop_front();
        action       <= cur_item.clear;
        sample_in    <= cur_item.smp;
        sample_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 99) < 2) begin
          send_calm = $urandom_range(30, 120);
          send_gap  = 0;
        end else begin
          send_gap = ($urandom_range(0, 99) < 50) ? 0 : gap_len();
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk) begin : result_monitor
    filt_result_t want;
    int           hold_left;
    int           stall_left;
    int           calm_left;
    int           r;
    logic         hold_done;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
      calm_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_outputs.size() == 0) begin
          report($sformatf("unexpected result beat, filtered_out %h", filtered_out));
        end else begin
          want = expected_outputs.pop_front();
          if (filtered_out !== want.y)
            report($sformatf("filtered_out %h, expected %h", filtered_out, want.y));
          if (saturated !== want.sat)
            report($sformatf("saturated %b, expected %b", saturated, want.sat));
        end
      end

      // long hold-off once, so the block backs up and stalls its input
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        result_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          calm_left = $urandom_range(30, 120);
          result_stall <= 1'b0;
        end else if (r < 25) begin
          stall_left = gap_len() - 1;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    logic [63:0] junk;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: zero, extremes, unit steps, clear
    push_item(1'b0, '0);
    push_item(1'b0, Q_MAX);
    push_item(1'b0, Q_MIN);
    push_item(1'b0, 32'hFFFF_FFFF);
    push_item(1'b0, 32'd1);
    push_item(1'b1, $urandom);
    drain();

    // order four, full step, extreme weights: derivative, state and output clips
    set_config(3'd4, 32'hFFFF_FFFF, {Q_MIN, Q_MAX}, {Q_MAX, Q_MIN},
               {Q_MAX, Q_MAX}, {Q_MIN, Q_MIN}, Q_MAX);
    push_item(1'b0, Q_MAX);
    push_item(1'b0, Q_MAX);
    push_item(1'b0, Q_MIN);
    push_item(1'b0, Q_MIN);
    push_item(1'b1, Q_MAX);
    push_item(1'b0, Q_MAX);
    drain();

    // order zero acts as one; zero step; most negative feedthrough
    set_config(3'd0, '0, {Q_ONE, Q_ONE}, {Q_ONE, Q_ONE},
               {Q_ONE, Q_ONE}, {Q_ONE, Q_ONE}, Q_MIN);
    junk = {$urandom, $urandom};
    write_reg(REG_UNUSED, junk);
    @(negedge clk);
    push_item(1'b0, Q_MAX);
    push_item(1'b0, Q_MIN);
    push_item(1'b0, '0);
    push_item(1'b1, '0);
    drain();

    // order seven acts as four; quarter step, modest weights
    set_config(3'd7, 32'h4000_0000, {32'h0000_8000, 32'h0002_0000},
               {32'hFFFF_0000, 32'h0000_4000}, {32'h0001_0000, 32'hFFFF_8000},
               {32'h0000_2000, 32'h0003_0000}, 32'h0000_8000);
    push_item(1'b0, Q_ONE);
    push_item(1'b0, Q_ONE);
    push_item(1'b0, Q_ONE);
    push_item(1'b0, 32'hFFFF_0000);
    push_item(1'b1, Q_ONE);
    drain();

    // random phases, each under fresh random settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config(3'($urandom_range(0, 7)), rand_step(), {rand_weight(), rand_weight()},
                 {rand_weight(), rand_weight()}, {rand_weight(), rand_weight()},
                 {rand_weight(), rand_weight()}, rand_weight());
      for (int k = 0; k < PHASE_ITEMS; k++)
        queued_samples.push_back(rand_item());
      if (p == RAND_PHASES / 3)
        hold_go = 1'b1;
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
